@@ design/rth_pkg.sv @@
package rth_pkg;

  // Which component holds the maximum. Ties go to red, then green.
  typedef enum logic [2:0] {
    MAX_RED   = 3'b001,
    MAX_GREEN = 3'b010,
    MAX_BLUE  = 3'b100
  } max_sel_t;

endpackage

@@ design/rth_if.sv @@
interface rgb_if #(
  parameter int COMPONENT_BITS = 8
) ();
  logic                      valid;
  logic                      ready;
  logic [COMPONENT_BITS-1:0] red;
  logic [COMPONENT_BITS-1:0] green;
  logic [COMPONENT_BITS-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface hsl_if #(
  parameter int COMPONENT_BITS = 8,
  parameter int HUE_BITS       = 12,
  parameter int FRACTION_BITS  = 12
) ();
  logic                      valid;
  logic                      ready;
  logic [HUE_BITS-1:0]       hue;
  logic [FRACTION_BITS:0]    saturation;
  logic [COMPONENT_BITS:0]   lightness_sum;

  modport source (output valid, output hue, output saturation, output lightness_sum,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness_sum,
                  output ready);
endinterface

@@ design/rgb_to_hsl.sv @@
// RGB to HSL converter, one pixel per clock while pixel_out is not stalled.
//
// pixel_in carries red, green and blue (COMPONENT_BITS each); pixel_out carries
// hue (HUE_BITS, 2^HUE_BITS is one full turn), saturation (FRACTION_BITS+1,
// 2^FRACTION_BITS is one) and lightness_sum (max + min, COMPONENT_BITS+1).
// Both channels use valid/ready; a transfer happens when both are high.
//
// Structure: stage A finds max/min, stage B forms the differences and the two
// divisors, then max(FRACTION_BITS+1, HUE_BITS) restoring-division stages: the
// first FRACTION_BITS+1 each retire a saturation bit, the first HUE_BITS a hue bit.
// Throughput: one pixel per cycle while the receiver keeps pixel_out.ready
// high; the division stages set the depth, not the rate.
//
// Reset (rst, synchronous) clears all stage valid bits; nothing else is kept.
// When the receiver holds ready low, the last stage holds its result and the
// stages behind it keep filling any empty slots, so pixel_in.ready drops only
// once every stage is occupied. Nothing is dropped or repeated.
module rgb_to_hsl #(
  parameter int COMPONENT_BITS = 8,
  parameter int HUE_BITS       = 12,
  parameter int FRACTION_BITS  = 12
) (
  input  logic  clk,
  input  logic  rst,
  rgb_if.sink   pixel_in,
  hsl_if.source pixel_out
);
  import rth_pkg::*;

  localparam int C     = COMPONENT_BITS;
  localparam int W6    = C + 3;                 // holds 6*d and the hue numerator
  localparam int STEPS = (FRACTION_BITS + 1 > HUE_BITS) ? FRACTION_BITS + 1 : HUE_BITS;
  localparam int N     = STEPS + 2;             // A, B and the divider stages
  localparam logic [C:0] FULL2 = {{(C){1'b1}}, 1'b0};           // 2*FULL
  localparam logic [FRACTION_BITS:0] SAT_ONE = {1'b1, {(FRACTION_BITS){1'b0}}};

  // stage valid bits and per-stage load enables
  logic [N-1:0] v;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = !v[N-1] || pixel_out.ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign pixel_in.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= pixel_in.valid;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // ---------------- stage A: max, min, which one is max ----------------
  logic [C-1:0] ra, ga, ba, mxa, mna;
  max_sel_t     sela;
  logic [C-1:0] mx_next, mn_next;
  max_sel_t     sel_next;

  always_comb begin
    if (pixel_in.red >= pixel_in.green && pixel_in.red >= pixel_in.blue) begin
      sel_next = MAX_RED;
      mx_next  = pixel_in.red;
    end else if (pixel_in.green >= pixel_in.blue) begin
      sel_next = MAX_GREEN;
      mx_next  = pixel_in.green;
    end else begin
      sel_next = MAX_BLUE;
      mx_next  = pixel_in.blue;
    end
    mn_next = pixel_in.red;
    if (pixel_in.green < mn_next) mn_next = pixel_in.green;
    if (pixel_in.blue < mn_next)  mn_next = pixel_in.blue;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ra   <= pixel_in.red;
      ga   <= pixel_in.green;
      ba   <= pixel_in.blue;
      mxa  <= mx_next;
      mna  <= mn_next;
      sela <= sel_next;
    end
  end

  // ---------------- divider stage payload, index 1 is stage B ----------------
  logic [C-1:0]           sat_rem [1:N-1];
  logic [C-1:0]           den     [1:N-1];
  logic [FRACTION_BITS:0] sat_q   [1:N-1];
  logic [W6-1:0]          hue_rem [1:N-1];
  logic [W6-1:0]          d6      [1:N-1];
  logic [HUE_BITS-1:0]    hue_q   [1:N-1];
  logic [C:0]             lsum    [1:N-1];

  // ---------------- stage B: differences, numerator, divisors ----------------
  logic [C-1:0]  d_b;
  logic [C:0]    sum_b;
  logic [C-1:0]  den_b;
  logic [W6-1:0] d6_b, num_b, dw_b;

  always_comb begin
    d_b   = mxa - mna;
    sum_b = {1'b0, mxa} + {1'b0, mna};
    dw_b  = W6'(d_b);
    // grey pixel: d is 0; nonzero divisors make both quotients come out 0
    if (d_b == '0) begin
      den_b = '1;
      d6_b  = W6'(1);
    end else begin
      den_b = (sum_b <= {1'b0, {(C){1'b1}}}) ? sum_b[C-1:0] : C'(FULL2 - sum_b);
      d6_b  = (dw_b << 2) + (dw_b << 1);
    end
    case (sela)
      MAX_RED: begin
        if (ga >= ba) num_b = W6'(ga - ba);
        else          num_b = d6_b - W6'(ba - ga);
      end
      MAX_GREEN: num_b = (dw_b << 1) + W6'(ba) - W6'(ra);
      MAX_BLUE:  num_b = (dw_b << 2) + W6'(ra) - W6'(ga);
      default:   num_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sat_rem[1] <= d_b;
      den[1]     <= den_b;
      sat_q[1]   <= '0;
      hue_rem[1] <= num_b;
      d6[1]      <= d6_b;
      hue_q[1]   <= '0;
      lsum[1]    <= sum_b;
    end
  end

  // ---------------- restoring division, one bit per stage ----------------
  for (genvar k = 2; k < N; k++) begin : g_div
    localparam int S = k - 2;   // step number within each division
    logic [C-1:0]           srem_next;
    logic [FRACTION_BITS:0] sq_next;
    logic [W6-1:0]          hrem_next;
    logic [HUE_BITS-1:0]    hq_next;
    logic [C:0]             st;
    logic [W6:0]            ht;

    always_comb begin
      // saturation: first step compares d itself (quotient can reach one)
      st = (S == 0) ? {1'b0, sat_rem[k-1]} : {sat_rem[k-1], 1'b0};
      srem_next = sat_rem[k-1];
      sq_next   = sat_q[k-1];
      if (S <= FRACTION_BITS) begin
        if (st >= {1'b0, den[k-1]}) begin
          srem_next = C'(st - {1'b0, den[k-1]});
          sq_next   = {sat_q[k-1][FRACTION_BITS-1:0], 1'b1};
        end else begin
          srem_next = st[C-1:0];
          sq_next   = {sat_q[k-1][FRACTION_BITS-1:0], 1'b0};
        end
      end
      // hue: numerator is below 6d, so every step shifts first
      ht = {hue_rem[k-1], 1'b0};
      hrem_next = hue_rem[k-1];
      hq_next   = hue_q[k-1];
      if (S < HUE_BITS) begin
        if (ht >= {1'b0, d6[k-1]}) begin
          hrem_next = W6'(ht - {1'b0, d6[k-1]});
          hq_next   = {hue_q[k-1][HUE_BITS-2:0], 1'b1};
        end else begin
          hrem_next = ht[W6-1:0];
          hq_next   = {hue_q[k-1][HUE_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        sat_rem[k] <= srem_next;
        den[k]     <= den[k-1];
        sat_q[k]   <= sq_next;
        hue_rem[k] <= hrem_next;
        d6[k]      <= d6[k-1];
        hue_q[k]   <= hq_next;
        lsum[k]    <= lsum[k-1];
      end
    end
  end

  assign pixel_out.valid         = v[N-1];
  assign pixel_out.hue           = hue_q[N-1];
  assign pixel_out.saturation    = sat_q[N-1];
  assign pixel_out.lightness_sum = lsum[N-1];

  // ---------------- checks ----------------
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !pixel_out.valid |-> pixel_in.ready)
    else $error("input stalled with empty output stage");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    pixel_out.valid |-> (pixel_out.saturation <= SAT_ONE))
    else $error("saturation above one");

  a_lsum_range: assert property (@(posedge clk) disable iff (rst)
    pixel_out.valid |-> (pixel_out.lightness_sum <= FULL2))
    else $error("lightness sum out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pixel_out.valid)
    else $error("output valid right after reset");

endmodule
